### rtl/epoch_seconds_to_calendar_assert.svh
// Assertion macros used by the checker of the calendar converter.
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/esc_pkg.sv
// Shared types, constants and the month table of the calendar converter.
package esc_pkg;

  localparam int EPOCH_W     = 32;
  localparam int ZONE_W      = 18;
  localparam int DIV_WIDTH   = 33;
  localparam int DIVISOR_W   = 16;
  localparam int RECIP_SHIFT = 33;
  localparam int RECIP_W     = 29;

  localparam logic signed [ZONE_W-1:0] ZONE_RESET = -18'sd28800;

  localparam logic [DIVISOR_W-1:0] DIV_MINUTE        = 16'd60;
  localparam logic [DIVISOR_W-1:0] DIV_CYCLE         = 16'd35064;
  localparam logic [DIVISOR_W-1:0] DIV_DAY           = 16'd24;
  localparam logic [DIVISOR_W-1:0] HOURS_COMMON_YEAR = 16'd8760;
  localparam logic [DIVISOR_W-1:0] HOURS_LEAP_EXTRA  = 16'd24;

  // Reciprocals rounded down; every dividend stays below 2**RECIP_SHIFT.
  localparam logic [RECIP_W-1:0] RECIP_MINUTE =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIV_MINUTE));
  localparam logic [RECIP_W-1:0] RECIP_CYCLE =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIV_CYCLE));
  localparam logic [RECIP_W-1:0] RECIP_DAY =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(DIV_DAY));

  localparam logic [7:0] YEAR_BASE  = 8'd70;
  localparam logic [8:0] LEAP_DAY   = 9'd60;
  localparam logic [3:0] LEAP_MONTH = 4'd1;
  localparam logic [4:0] LEAP_MDAY  = 5'd29;
  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_SEC,
    OP_MIN,
    OP_CYCLE,
    OP_YEAR,
    OP_HOUR,
    OP_LEAP,
    OP_MONTH
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_found;
    logic leap_day;
    logic month_found;
  } dp_status_t;

  // Lengths of the months in a common year.
  function automatic logic [4:0] month_days(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/esc_divider.sv
// Shared divider by a constant: reciprocal multiply, remainder and one correction step.
module esc_divider import esc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_WIDTH-1:0] dividend,
  input  logic [DIVISOR_W-1:0] divisor,
  input  logic [RECIP_W-1:0]   recip,
  output logic [DIV_WIDTH-1:0] quotient,
  output logic [DIVISOR_W-1:0] remainder,
  output logic                 done
);

  localparam int PROD_W = DIV_WIDTH + RECIP_W;

  logic [2:0]           stage;
  logic [DIV_WIDTH-1:0] x;
  logic [DIVISOR_W-1:0] dsr;
  logic [RECIP_W-1:0]   rcp;
  logic [PROD_W-1:0]    product;
  logic [DIV_WIDTH-1:0] q_est;
  logic [DIV_WIDTH-1:0] q_dsr;
  logic [DIV_WIDTH-1:0] r_full;
  logic [DIVISOR_W:0]   r_est;

  // The reciprocal is rounded down, so the estimate is exact or one short.
  assign product = PROD_W'(x) * PROD_W'(rcp);
  assign q_dsr   = q_est * DIV_WIDTH'(dsr);
  assign r_full  = x - q_dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= dividend;
      dsr <= divisor;
      rcp <= recip;
    end
    if (stage[0]) q_est <= DIV_WIDTH'(product >> RECIP_SHIFT);
    if (stage[1]) r_est <= r_full[DIVISOR_W:0];
    if (stage[2]) begin
      if (r_est >= {1'b0, dsr}) begin
        quotient  <= q_est + DIV_WIDTH'(1);
        remainder <= DIVISOR_W'(r_est - {1'b0, dsr});
      end else begin
        quotient  <= q_est;
        remainder <= r_est[DIVISOR_W-1:0];
      end
    end
  end

endmodule

### rtl/esc_datapath.sv
// Datapath: zone adjust, divisions, year stepping, leap-day check and month walk.
module esc_datapath import esc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  output dp_status_t               status,
  input  logic [EPOCH_W-1:0]       epoch_seconds,
  input  logic signed [ZONE_W-1:0] zone,
  output logic [5:0]               second,
  output logic [5:0]               minute,
  output logic [4:0]               hour,
  output logic [4:0]               day_of_month,
  output logic [3:0]               month_index,
  output logic [7:0]               years_since_1900
);

  logic [33:0]          diff;
  logic [32:0]          t_clamped;
  logic                 div_start;
  logic [DIV_WIDTH-1:0] div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic [RECIP_W-1:0]   div_recip;
  logic [DIV_WIDTH-1:0] quotient;
  logic [DIVISOR_W-1:0] remainder;
  logic                 div_done;
  logic [DIVISOR_W-1:0] hrs;
  logic [8:0]           day;
  logic                 leap;
  logic [DIVISOR_W-1:0] year_len;
  logic [4:0]           month_len;

  // The difference fits a 34-bit signed value, so bit 33 is the sign.
  assign diff      = {2'b00, epoch_seconds} - {{(34 - ZONE_W){zone[ZONE_W-1]}}, zone};
  assign t_clamped = diff[33] ? '0 : diff[32:0];

  assign leap      = (years_since_1900[1:0] == 2'b00);
  assign year_len  = HOURS_COMMON_YEAR + (leap ? HOURS_LEAP_EXTRA : '0);
  assign month_len = month_days(month_index);

  assign status.div_done    = div_done;
  assign status.year_found  = (hrs < year_len);
  assign status.leap_day    = leap && (day == LEAP_DAY);
  assign status.month_found = (month_index == LAST_MONTH) || !({4'b0000, month_len} < day);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_WIDTH'(t_clamped);
    div_divisor  = DIV_MINUTE;
    div_recip    = RECIP_MINUTE;
    case (cmd.op)
      OP_IDLE: begin
        div_start = cmd.load;
      end
      OP_SEC: begin
        div_start    = div_done;
        div_dividend = quotient;
      end
      OP_MIN: begin
        div_start    = div_done;
        div_dividend = quotient;
        div_divisor  = DIV_CYCLE;
        div_recip    = RECIP_CYCLE;
      end
      OP_YEAR: begin
        div_start    = status.year_found;
        div_dividend = DIV_WIDTH'(hrs);
        div_divisor  = DIV_DAY;
        div_recip    = RECIP_DAY;
      end
      default: begin
      end
    endcase
  end

  esc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .recip    (div_recip),
    .quotient (quotient),
    .remainder(remainder),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SEC: begin
        if (div_done) second <= remainder[5:0];
      end
      OP_MIN: begin
        if (div_done) minute <= remainder[5:0];
      end
      OP_CYCLE: begin
        // At most 34 whole four-year spans of hours fit the widest adjusted count.
        if (div_done) begin
          years_since_1900 <= {quotient[5:0], 2'b00} + YEAR_BASE;
          hrs              <= remainder;
        end
      end
      OP_YEAR: begin
        if (!status.year_found) begin
          hrs              <= hrs - year_len;
          years_since_1900 <= years_since_1900 + 8'd1;
        end
      end
      OP_HOUR: begin
        if (div_done) begin
          hour <= remainder[4:0];
          day  <= quotient[8:0] + 9'd1;
        end
      end
      OP_LEAP: begin
        if (status.leap_day) begin
          month_index  <= LEAP_MONTH;
          day_of_month <= LEAP_MDAY;
        end else begin
          month_index <= '0;
          // Past Feb 29 the common-year table applies one day earlier.
          if (leap && (day > LEAP_DAY)) day <= day - 9'd1;
        end
      end
      OP_MONTH: begin
        if (!status.month_found) begin
          day         <= day - {4'b0000, month_len};
          month_index <= month_index + 4'd1;
        end else begin
          day_of_month <= day[4:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/esc_ctrl.sv
// Controller that sequences the conversion steps of one timestamp.
module esc_ctrl import esc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_CYCLE,
    S_YEAR,
    S_HOUR,
    S_LEAP,
    S_MONTH,
    S_DONE
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    cmd.load = start && (state == S_IDLE);
    case (state)
      S_SEC:   cmd.op = OP_SEC;
      S_MIN:   cmd.op = OP_MIN;
      S_CYCLE: cmd.op = OP_CYCLE;
      S_YEAR:  cmd.op = OP_YEAR;
      S_HOUR:  cmd.op = OP_HOUR;
      S_LEAP:  cmd.op = OP_LEAP;
      S_MONTH: cmd.op = OP_MONTH;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (start) state <= S_SEC;
        S_SEC:   if (status.div_done) state <= S_MIN;
        S_MIN:   if (status.div_done) state <= S_CYCLE;
        S_CYCLE: if (status.div_done) state <= S_YEAR;
        S_YEAR:  if (status.year_found) state <= S_HOUR;
        S_HOUR:  if (status.div_done) state <= S_LEAP;
        S_LEAP:  state <= status.leap_day ? S_DONE : S_MONTH;
        S_MONTH: if (status.month_found) state <= S_DONE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/epoch_seconds_to_calendar.sv
// Top level of the Unix timestamp to calendar converter.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------
//   input    | start, busy        | epoch_seconds
//   result   | done               | second, minute, hour, day_of_month,
//            |                    | month_index, years_since_1900
//   config   | psel, penable, ... | paddr, pwdata, prdata (zone_offset_seconds)
//
// After the input beat the result follows four divider passes, year stepping, one leap
// check and a month walk (skipped on Feb 29), and is taken in the done cycle.
// busy is high from the cycle after accept through the done cycle.
// Results stand for the single done cycle; the receiver cannot stall them.
// Synchronous reset returns to idle and loads the zone offset with -28800.
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [EPOCH_W-1:0] epoch_seconds,
  output logic               done,
  output logic [5:0]         second,
  output logic [5:0]         minute,
  output logic [4:0]         hour,
  output logic [4:0]         day_of_month,
  output logic [3:0]         month_index,
  output logic [7:0]         years_since_1900,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [ZONE_W-1:0] zone;
  dp_cmd_t                  cmd;
  dp_status_t               status;
  logic                     zone_sel;

  assign pready   = 1'b1;
  assign zone_sel = (paddr[2] == 1'b0);
  assign prdata   = zone_sel ? {{(32 - ZONE_W){zone[ZONE_W-1]}}, zone} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ZONE_RESET;
    end else if (psel && penable && pwrite && pready && zone_sel) begin
      zone <= pwdata[ZONE_W-1:0];
    end
  end

  esc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  esc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .epoch_seconds   (epoch_seconds),
    .zone            (zone),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .day_of_month    (day_of_month),
    .month_index     (month_index),
    .years_since_1900(years_since_1900)
  );

endmodule

### rtl/esc_checker.sv
// Port-level checker for the calendar converter and its bind.
`include "epoch_seconds_to_calendar_assert.svh"

module esc_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [5:0] second,
  input logic [5:0] minute,
  input logic [4:0] hour,
  input logic [4:0] day_of_month,
  input logic [3:0] month_index
);

  logic time_ok;
  logic date_ok;

  assign time_ok = (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24);
  assign date_ok = (month_index < 4'd12) && (day_of_month != 5'd0);

  `ESC_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "busy missing after accept")
  `ESC_ASSERT_IMP(a_done_in_busy, done, busy, "result strobe outside a busy period")
  `ESC_ASSERT_NXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
  `ESC_ASSERT_IMP(a_time_range, done, time_ok, "time of day out of range")
  `ESC_ASSERT_IMP(a_date_range, done, date_ok, "date out of range")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .second      (second),
  .minute      (minute),
  .hour        (hour),
  .day_of_month(day_of_month),
  .month_index (month_index)
);

### tb/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Self-checking testbench for the epoch seconds to calendar converter.
module tb_epoch_seconds_to_calendar;
  import esc_pkg::*;

  localparam logic [2:0] ZONE_ADDR   = 3'd0;
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int HOURS_PER_CYCLE = 1461 * 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int month_len [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int cycle_year_day [0:3] = '{0, 365, 730, 1096};
  localparam int key_day [0:6] = '{0, 1, 58, 59, 60, 364, 365};

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
  } calendar_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [EPOCH_W-1:0] epoch_seconds = '0;
  logic               done;
  logic [5:0]         second;
  logic [5:0]         minute;
  logic [4:0]         hour;
  logic [4:0]         day_of_month;
  logic [3:0]         month_index;
  logic [7:0]         years_since_1900;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [EPOCH_W-1:0]       epoch_backlog [$];
  calendar_t                due_dates [$];
  logic signed [ZONE_W-1:0] zone_model = ZONE_RESET;
  int  items_queued = 0;
  int  items_taken = 0;
  int  zone_writes = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  epoch_seconds_to_calendar u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .epoch_seconds(epoch_seconds),
    .done(done), .second(second), .minute(minute), .hour(hour),
    .day_of_month(day_of_month), .month_index(month_index),
    .years_since_1900(years_since_1900), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Calendar date of a timestamp; every fourth year is taken as a leap year.
  function automatic calendar_t civil_from_epoch(logic [EPOCH_W-1:0] epoch,
                                                 logic signed [ZONE_W-1:0] zone);
    longint zl, adj, t, hrs, span, day;
    int yr, mon;
    calendar_t c;
    zl = zone;
    adj = longint'({32'd0, epoch}) - zl;
    if (adj < 0) adj = 0;
    c.second = 6'(adj % 60);
    t = adj / 60;
    c.minute = 6'(t % 60);
    hrs = t / 60;
    yr = 70 + 4 * int'(hrs / HOURS_PER_CYCLE);
    hrs = hrs % HOURS_PER_CYCLE;
    span = (yr % 4 == 0) ? 8784 : 8760;
    while (hrs >= span) begin
      hrs -= span;
      yr++;
      span = (yr % 4 == 0) ? 8784 : 8760;
    end
    c.hour = 5'(hrs % 24);
    day = hrs / 24 + 1;
    mon = 0;
    if (yr % 4 == 0 && day == 60) begin
      mon = 1;
      day = 29;
    end else begin
      if (yr % 4 == 0 && day > 60) day--;
      while (mon < 11 && day > month_len[mon]) begin
        day -= month_len[mon];
        mon++;
      end
    end
    c.day_of_month = 5'(day);
    c.month_index = 4'(mon);
    c.years_since_1900 = 8'(yr);
    return c;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Local times near midnight, year ends and leap days, plus plain random timestamps.
  function automatic logic [EPOCH_W-1:0] pick_epoch();
    longint day, s;
    int pick, jitter;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom;
    if (pick < 7) day = $urandom_range(0, 49709);
    else day = longint'($urandom_range(0, 33)) * 1461 + cycle_year_day[$urandom_range(0, 3)]
               + key_day[$urandom_range(0, 6)];
    if ($urandom_range(0, 2) == 0) jitter = $urandom_range(0, 86399);
    else jitter = $urandom_range(0, 4);
    jitter -= 2;
    s = day * 86400 + jitter + zone_model;
    return s[EPOCH_W-1:0];
  endfunction

  // Driver: one beat per accept, with random gaps between beats outside the steady batches.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        due_dates.push_back(civil_from_epoch(epoch_seconds, zone_model));
        items_taken++;
        gap_left = steady ? 0 : draw_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (epoch_backlog.size() != 0) begin
          start <= 1'b1;
          epoch_seconds <= epoch_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each done beat is checked against the oldest predicted date.
  always @(posedge clk) begin
    calendar_t want;
    if (!rst && done) begin
      if (due_dates.size() == 0) begin
        flag_mismatch("result with no conversion outstanding");
      end else begin
        want = due_dates.pop_front();
        if (second !== want.second)
          flag_mismatch($sformatf("second %0d, want %0d", second, want.second));
        if (minute !== want.minute)
          flag_mismatch($sformatf("minute %0d, want %0d", minute, want.minute));
        if (hour !== want.hour)
          flag_mismatch($sformatf("hour %0d, want %0d", hour, want.hour));
        if (day_of_month !== want.day_of_month)
          flag_mismatch($sformatf("day_of_month %0d, want %0d", day_of_month,
                                  want.day_of_month));
        if (month_index !== want.month_index)
          flag_mismatch($sformatf("month_index %0d, want %0d", month_index,
                                  want.month_index));
        if (years_since_1900 !== want.years_since_1900)
          flag_mismatch($sformatf("years_since_1900 %0d, want %0d", years_since_1900,
                                  want.years_since_1900));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d dates outstanding", due_dates.size());
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_epoch(input logic [EPOCH_W-1:0] e);
    epoch_backlog.push_back(e);
    items_queued++;
  endtask

  task automatic settle();
    while (items_taken != items_queued || due_dates.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [ZONE_W-1:0] bits);
    logic [31:0] word;
    word = $urandom;
    word[ZONE_W-1:0] = bits;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ZONE_ADDR) begin
      zone_model = bits;
      zone_writes++;
    end
  endtask

  task automatic check_zone_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ZONE_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[ZONE_W-1:0] !== zone_model)
      flag_mismatch($sformatf("zone readback %h, want %h", prdata[ZONE_W-1:0], zone_model));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_zone(input logic [ZONE_W-1:0] bits);
    apb_write(ZONE_ADDR, bits);
    check_zone_readback();
  endtask

  initial begin
    int zone_val;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset offset of minus eight hours, then the directed corners.
    check_zone_readback();
    queue_epoch('0);
    queue_epoch('1);
    settle();

    set_zone(18'sd0);
    foreach (key_day[i]) ;
    queue_epoch(32'd0);
    queue_epoch(32'd59);
    queue_epoch(32'd60);
    queue_epoch(32'd3599);
    queue_epoch(32'd86399);
    queue_epoch(32'd68169599);     // last second before the 1972 leap day
    queue_epoch(32'd68169600);     // the 1972 leap day
    queue_epoch(32'd68256000);     // first of March 1972
    queue_epoch(32'd94694399);     // last second of a leap year
    queue_epoch(32'd951782400);
    queue_epoch(32'd978307199);
    queue_epoch(32'd4107542400);   // 2100 is still taken as a leap year
    queue_epoch(32'h7FFFFFFF);
    queue_epoch(32'hAAAAAAAA);
    queue_epoch(32'h55555555);
    settle();

    // A large positive offset pushes early timestamps below zero.
    set_zone(18'sd86399);
    queue_epoch(32'd0);
    queue_epoch(32'd86398);
    queue_epoch(32'd86399);
    settle();

    set_zone(-18'sd86399);
    queue_epoch('1);
    settle();

    // Offset patterns at the extremes of the 18-bit field.
    set_zone(18'h20000);
    queue_epoch('1);
    queue_epoch('0);
    settle();
    set_zone(18'h1FFFF);
    queue_epoch(32'd131070);
    queue_epoch(32'd131071);
    settle();

    // A write to an address past the register file must leave the offset alone.
    apb_write(UNUSED_ADDR, 18'h15555);
    check_zone_readback();

    for (int batch = 0; batch < 9; batch++) begin
      if (batch % 4 == 3) begin
        set_zone(18'($urandom));
      end else begin
        zone_val = $urandom_range(0, 172798);
        zone_val -= 86399;
        set_zone(18'(zone_val));
      end
      steady = (batch % 3 == 1);
      for (int k = 0; k < 80; k++) queue_epoch(pick_epoch());
      settle();
    end

    repeat (60) @(posedge clk);
    if (due_dates.size() != 0)
      flag_mismatch($sformatf("%0d dates never produced", due_dates.size()));
    $display("covered %0d conversions under %0d zone offset settings, %0d mismatches",
             items_taken, zone_writes + 1, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
